@@ design/axis_reduce_sum_3d_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the 3-D axis sum reduction unit
// Short forms for clocked implication checks, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_REDUCE_SUM_3D_UNIT_MACROS_SVH
`define AXIS_REDUCE_SUM_3D_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ARS3D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ARS3D_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ars3d_pkg.sv @@
// ----------------------------------------------------------------------------
// ars3d_pkg
// Shared types and constants for the 3-D axis sum reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ars3d_pkg;

  // Default sizing of the unit.
  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned ACC_DEPTH_DEF  = 4096;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int unsigned TOTAL_W     = 44;
  localparam int unsigned OUT_IDX_W   = 12;
  localparam int unsigned DIM_CFG_W   = 13;
  localparam int unsigned AXIS_W      = 2;
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = ((TOTAL_W + OUT_IDX_W + 7) / 8) * 8;

  // Register map, word index into the configuration space.
  typedef enum logic [1:0] {
    REG_DIM_OUTER  = 2'd0,
    REG_DIM_MIDDLE = 2'd1,
    REG_DIM_INNER  = 2'd2,
    REG_AXIS       = 2'd3
  } reg_sel_t;

  // Axis that is summed over; the zero code is not a valid axis.
  typedef enum logic [AXIS_W-1:0] {
    AXIS_NONE   = 2'd0,
    AXIS_OUTER  = 2'd1,
    AXIS_MIDDLE = 2'd2,
    AXIS_INNER  = 2'd3
  } axis_t;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET  = 13'd1;
  localparam axis_t                AXIS_RESET = AXIS_INNER;

  // Per-beat control flags carried down the accumulate stage.
  typedef struct packed {
    logic first;
    logic done;
    logic frame_end;
    logic err;
  } item_ctl_t;

endpackage

`default_nettype wire

@@ design/axis_reduce_sum_3d_unit.sv @@
// ----------------------------------------------------------------------------
// axis_reduce_sum_3d_unit
// Streaming sum of a row-major 3-D array along one configured axis.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the in_ stream, one beat per array element in row-major
//   order (outer, middle, inner). Each beat reads one accumulator entry,
//   adds the sample and writes it back; the first contribution of a frame
//   overwrites the entry, so no clearing pass is needed after reset or
//   between frames. A result beat leaves on the out_ stream as soon as the
//   last contribution to an element is in: tdata holds the total and its
//   index, tlast marks the end of the frame, tuser flags a size error.
//   Throughput is one beat per cycle without stalls or configuration
//   writes, set by the single read-modify-write of the accumulator memory;
//   a write-back forwarding register covers back-to-back beats to the same
//   entry. After each configuration write, in_tready is low in the next
//   cycle while the size check is recomputed; the write restarts the frame.
//   Reset restarts the frame with all dimensions 1 and the inner axis
//   selected. When the receiver stalls, one result waits in the output
//   register and one beat in the accumulate stage; beats that produce no
//   result keep flowing until a second result would be needed.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_reduce_sum_3d_unit #(
  parameter int unsigned MAX_DIM    = ars3d_pkg::MAX_DIM_DEF,
  parameter int unsigned ACC_DEPTH  = ars3d_pkg::ACC_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ars3d_pkg::DATA_WIDTH_DEF,
  localparam int unsigned IN_W      = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // Input stream
  input  wire logic                                  in_tvalid,
  output      logic                                  in_tready,
  input  wire logic [IN_W-1:0]                       in_tdata,     // sample
  // Result stream
  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  output      logic [ars3d_pkg::OUT_TDATA_W-1:0]     out_tdata,    // total, out_index
  output      logic                                  out_tlast,    // frame_last
  output      logic [0:0]                            out_tuser,    // size_error
  // Configuration port
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [ars3d_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  wire logic [ars3d_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output      logic [ars3d_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output      logic                                  cfg_pready
);

`include "axis_reduce_sum_3d_unit_macros.svh"

  localparam int unsigned PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned DW = PW + 1;
  localparam int unsigned IW = $clog2(ACC_DEPTH);
  localparam int unsigned TW = ars3d_pkg::TOTAL_W;

  // Clamp a configured size into 1..MAX_DIM.
  function automatic logic [DW-1:0] eff_dim(input logic [ars3d_pkg::DIM_CFG_W-1:0] d);
    logic [31:0] dx;
    dx = 32'(d);
    if (dx == 32'd0) begin
      return DW'(1);
    end else if (dx > MAX_DIM) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(dx);
    end
  endfunction

  // Configuration registers
  logic [ars3d_pkg::DIM_CFG_W-1:0] dim_outer_r, dim_middle_r, dim_inner_r;
  ars3d_pkg::axis_t                axis_r;
  logic                            cfg_wr;
  logic                            cfg_pend_r;
  logic                            size_err_r;

  // Frame position and accumulator index counters
  logic [PW-1:0] pos_o_r, pos_m_r, pos_i_r;
  logic [PW-1:0] pos_o_nxt, pos_m_nxt, pos_i_nxt;
  logic [IW-1:0] idx_r, idx_nxt, base_r, base_nxt;

  // Accumulate stage
  logic                  s1_valid_r;
  ars3d_pkg::item_ctl_t  s1_ctl_r;
  logic [IW-1:0]         s1_idx_r;
  logic [TW-1:0]         s1_smp_r;
  logic [TW-1:0]         rd_data_r;

  // Write-back forwarding
  logic          fwd_valid_r;
  logic [IW-1:0] fwd_idx_r;
  logic [TW-1:0] fwd_data_r;

  // Output register
  logic                                out_valid_r;
  logic [TW-1:0]                       out_total_r;
  logic [ars3d_pkg::OUT_IDX_W-1:0]     out_index_r;
  logic                                out_last_r;
  logic                                out_err_r;

  logic [TW-1:0] acc_mem [ACC_DEPTH];

  // Effective sizes and wrap points
  logic [DW-1:0]   l1, l2, l3;
  logic [PW-1:0]   lm1_o, lm1_m, lm1_i;
  logic [2*DW-1:0] kept_cnt;
  logic            size_err_nxt;

  always_comb begin
    l1    = eff_dim(dim_outer_r);
    l2    = eff_dim(dim_middle_r);
    l3    = eff_dim(dim_inner_r);
    lm1_o = PW'(l1 - DW'(1));
    lm1_m = PW'(l2 - DW'(1));
    lm1_i = PW'(l3 - DW'(1));
  end

  // Number of kept outputs for the selected axis, checked against the store.
  always_comb begin
    unique case (axis_r)
      ars3d_pkg::AXIS_OUTER:  kept_cnt = (2*DW)'(l2) * (2*DW)'(l3);
      ars3d_pkg::AXIS_MIDDLE: kept_cnt = (2*DW)'(l1) * (2*DW)'(l3);
      ars3d_pkg::AXIS_INNER:  kept_cnt = (2*DW)'(l1) * (2*DW)'(l2);
      default:                kept_cnt = '0;
    endcase
    size_err_nxt = (axis_r == ars3d_pkg::AXIS_NONE) ||
                   (64'(kept_cnt) > 64'(ACC_DEPTH));
  end

  // Configuration port: writes land in the access phase.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (ars3d_pkg::reg_sel_t'(cfg_paddr[3:2]))
      ars3d_pkg::REG_DIM_OUTER:  cfg_prdata = 32'(dim_outer_r);
      ars3d_pkg::REG_DIM_MIDDLE: cfg_prdata = 32'(dim_middle_r);
      ars3d_pkg::REG_DIM_INNER:  cfg_prdata = 32'(dim_inner_r);
      ars3d_pkg::REG_AXIS:       cfg_prdata = 32'(axis_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_outer_r  <= ars3d_pkg::DIM_RESET;
      dim_middle_r <= ars3d_pkg::DIM_RESET;
      dim_inner_r  <= ars3d_pkg::DIM_RESET;
      axis_r       <= ars3d_pkg::AXIS_RESET;
      cfg_pend_r   <= 1'b1;
      size_err_r   <= 1'b0;
    end else begin
      cfg_pend_r <= cfg_wr;
      size_err_r <= size_err_nxt;
      if (cfg_wr) begin
        unique case (ars3d_pkg::reg_sel_t'(cfg_paddr[3:2]))
          ars3d_pkg::REG_DIM_OUTER:  dim_outer_r  <= cfg_pwdata[ars3d_pkg::DIM_CFG_W-1:0];
          ars3d_pkg::REG_DIM_MIDDLE: dim_middle_r <= cfg_pwdata[ars3d_pkg::DIM_CFG_W-1:0];
          ars3d_pkg::REG_DIM_INNER:  dim_inner_r  <= cfg_pwdata[ars3d_pkg::DIM_CFG_W-1:0];
          ars3d_pkg::REG_AXIS:
            axis_r <= ars3d_pkg::axis_t'(cfg_pwdata[ars3d_pkg::AXIS_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  // Handshake between the stages.
  logic                 s1_emit, s1_go, out_free, in_acc, mem_we;
  logic                 o_last, m_last, i_last;
  ars3d_pkg::item_ctl_t ctl_now;

  assign s1_emit   = s1_ctl_r.err ? s1_ctl_r.frame_end : s1_ctl_r.done;
  assign out_free  = !out_valid_r || out_tready;
  assign s1_go     = s1_valid_r && (!s1_emit || out_free);
  assign in_tready = !cfg_pend_r && (!s1_valid_r || s1_go);
  assign in_acc    = in_tvalid && in_tready;
  assign mem_we    = s1_go && !s1_ctl_r.err;

  // Classify the incoming beat from the current position.
  always_comb begin
    o_last = pos_o_r >= lm1_o;
    m_last = pos_m_r >= lm1_m;
    i_last = pos_i_r >= lm1_i;
    ctl_now.frame_end = o_last && m_last && i_last;
    ctl_now.err       = size_err_r;
    unique case (axis_r)
      ars3d_pkg::AXIS_OUTER: begin
        ctl_now.first = (pos_o_r == '0);
        ctl_now.done  = o_last;
      end
      ars3d_pkg::AXIS_MIDDLE: begin
        ctl_now.first = (pos_m_r == '0);
        ctl_now.done  = m_last;
      end
      ars3d_pkg::AXIS_INNER: begin
        ctl_now.first = (pos_i_r == '0);
        ctl_now.done  = i_last;
      end
      default: begin
        ctl_now.first = 1'b0;
        ctl_now.done  = 1'b0;
      end
    endcase
  end

  // Advance the position and the running accumulator index.
  always_comb begin
    pos_i_nxt = i_last ? '0 : pos_i_r + PW'(1);
    pos_m_nxt = !i_last ? pos_m_r : (m_last ? '0 : pos_m_r + PW'(1));
    pos_o_nxt = !(i_last && m_last) ? pos_o_r : (o_last ? '0 : pos_o_r + PW'(1));
    idx_nxt   = idx_r;
    base_nxt  = base_r;
    unique case (axis_r)
      ars3d_pkg::AXIS_OUTER: begin
        idx_nxt = (m_last && i_last) ? '0 : idx_r + IW'(1);
      end
      ars3d_pkg::AXIS_MIDDLE: begin
        priority if (!i_last) begin
          idx_nxt = idx_r + IW'(1);
        end else if (!m_last) begin
          idx_nxt = base_r;
        end else if (!o_last) begin
          idx_nxt  = idx_r + IW'(1);
          base_nxt = idx_r + IW'(1);
        end else begin
          idx_nxt  = '0;
          base_nxt = '0;
        end
      end
      ars3d_pkg::AXIS_INNER: begin
        idx_nxt = ctl_now.frame_end ? '0 : (i_last ? idx_r + IW'(1) : idx_r);
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_o_r <= '0;
      pos_m_r <= '0;
      pos_i_r <= '0;
      idx_r   <= '0;
      base_r  <= '0;
    end else if (cfg_wr) begin
      pos_o_r <= '0;
      pos_m_r <= '0;
      pos_i_r <= '0;
      idx_r   <= '0;
      base_r  <= '0;
    end else if (in_acc) begin
      pos_o_r <= pos_o_nxt;
      pos_m_r <= pos_m_nxt;
      pos_i_r <= pos_i_nxt;
      idx_r   <= idx_nxt;
      base_r  <= base_nxt;
    end
  end

  // Sign-extend the sample into the accumulator width.
  logic [63:0] smp_ext;
  assign smp_ext = 64'(signed'(in_tdata[DATA_WIDTH-1:0]));

  // Accumulate stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl_r <= ctl_now;
      s1_idx_r <= idx_r;
      s1_smp_r <= smp_ext[TW-1:0];
    end
  end

  // Read-modify-write with forwarding of the previous write-back.
  logic [TW-1:0] acc_old, acc_new;
  always_comb begin
    acc_old = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : rd_data_r;
    acc_new = s1_ctl_r.first ? s1_smp_r : acc_old + s1_smp_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[s1_idx_r] <= acc_new;
    end
    if (in_acc && !ctl_now.err) begin
      rd_data_r <= acc_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (mem_we) begin
      fwd_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= acc_new;
    end
  end

  // Output register
  logic [31:0] s1_idx_ext;
  assign s1_idx_ext = 32'(s1_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_err_r  <= s1_ctl_r.err;
      out_last_r <= s1_ctl_r.frame_end;
      if (s1_ctl_r.err) begin
        out_total_r <= '0;
        out_index_r <= '0;
      end else begin
        out_total_r <= acc_new;
        out_index_r <= s1_idx_ext[ars3d_pkg::OUT_IDX_W-1:0];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ars3d_pkg::OUT_TDATA_W'({out_index_r, out_total_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // Checks
  `ARS3D_ASSERT_NXT(a_cfg_blocks_input, cfg_wr, !in_tready,
                    "input accepted in the cycle after a configuration write")
  `ARS3D_ASSERT_IMP(a_err_no_write, s1_valid_r && s1_ctl_r.err, !mem_we,
                    "accumulator written for a beat with a size error")
  `ARS3D_ASSERT_IMP(a_stall_blocks_input, s1_valid_r && !s1_go, !in_tready,
                    "input accepted while the accumulate stage is stalled")
  `ARS3D_ASSERT_IMP(a_err_result_form, out_valid_r && out_err_r,
                    out_last_r && (out_total_r == '0) && (out_index_r == '0),
                    "size error result is not an empty frame-end beat")
  `ARS3D_ASSERT_NXT(a_fwd_tracks_write, mem_we,
                    fwd_valid_r && (fwd_idx_r == $past(s1_idx_r)),
                    "forwarding register lost the last write-back")

endmodule

`default_nettype wire
